// ===== src/csv_field_tokenizer_assert.svh =====
// Assertion macros shared by the tokenizer RTL.
`ifndef CSV_FIELD_TOKENIZER_ASSERT_SVH
`define CSV_FIELD_TOKENIZER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CSVT_ASSERT_NOW(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define CSVT_ASSERT_NEXT(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error(msg);

`endif

// ===== src/csvt_pkg.sv =====
`timescale 1ns / 1ps

package csvt_pkg;

	localparam int unsigned BYTE_W = 8;
	localparam int unsigned CFG_INDEX_W = 2;
	localparam int unsigned OUT_TDATA_W = 16;

	localparam logic [BYTE_W-1:0] CHAR_CR = 8'd13;
	localparam logic [BYTE_W-1:0] CHAR_LF = 8'd10;
	localparam logic [BYTE_W-1:0] RESET_DELIM = 8'd44;
	localparam logic [BYTE_W-1:0] RESET_QUOTE = 8'd34;

	localparam logic [CFG_INDEX_W-1:0] REG_DELIMITER = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_QUOTE = 2'd1;

	typedef struct packed {
		logic present;
		logic char_valid;
		logic [BYTE_W-1:0] content_char;
		logic field_end;
		logic row_end;
		logic field_empty;
	} csvt_result_t;

	typedef struct packed {
		logic in_quotes;
		logic quote_seen_in_quotes;
		logic after_carriage_return;
		logic field_has_chars;
		logic row_open;
	} csvt_state_t;

endpackage

// ===== src/csvt_step.sv =====
`timescale 1ns / 1ps

module csvt_step (
	input  logic clk,
	input  logic arst_n,
	input  logic advance,
	input  logic [csvt_pkg::BYTE_W-1:0] data_byte,
	input  logic end_of_file,
	input  logic [csvt_pkg::BYTE_W-1:0] delimiter_char,
	input  logic [csvt_pkg::BYTE_W-1:0] quote_char,
	output csvt_pkg::csvt_result_t result,
	output csvt_pkg::csvt_state_t state
);
	import csvt_pkg::*;

	csvt_state_t st_q;
	csvt_state_t st_next;

	always_comb begin
		logic valid;
		logic fe;
		logic re;
		logic handled;
		logic skipped;
		logic has_chars;
		logic open_row;
		valid = 1'b0;
		fe = 1'b0;
		re = 1'b0;
		handled = 1'b0;
		skipped = 1'b0;
		st_next = st_q;

		if (st_q.in_quotes) begin
			if (st_q.quote_seen_in_quotes) begin
				st_next.quote_seen_in_quotes = 1'b0;
				if (data_byte == quote_char) begin
					valid = 1'b1;
					handled = 1'b1;
				end else begin
					st_next.in_quotes = 1'b0;
				end
			end else if (data_byte == quote_char) begin
				st_next.quote_seen_in_quotes = 1'b1;
				handled = 1'b1;
			end else begin
				valid = 1'b1;
				handled = 1'b1;
			end
		end

		if (!handled) begin
			if (st_q.after_carriage_return && data_byte == CHAR_LF) begin
				skipped = 1'b1;
			end else if (data_byte == quote_char) begin
				st_next.in_quotes = 1'b1;
			end else if (data_byte == delimiter_char) begin
				fe = 1'b1;
			end else if (data_byte == CHAR_CR || data_byte == CHAR_LF) begin
				fe = 1'b1;
				re = 1'b1;
			end else begin
				valid = 1'b1;
			end
			st_next.after_carriage_return = !skipped && data_byte == CHAR_CR && re;
		end

		open_row = st_q.row_open || !skipped;
		has_chars = st_q.field_has_chars || valid;
		if (end_of_file && open_row && !re) begin
			fe = 1'b1;
			re = 1'b1;
		end

		result.present = valid || fe;
		result.char_valid = valid;
		result.content_char = valid ? data_byte : '0;
		result.field_end = fe;
		result.row_end = re;
		result.field_empty = fe && !has_chars;

		st_next.field_has_chars = has_chars && !fe;
		st_next.row_open = open_row && !re;
		if (end_of_file) begin
			st_next = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= '0;
		end else if (advance) begin
			st_q <= st_next;
		end
	end

	assign state = st_q;

endmodule

// ===== src/csv_field_tokenizer.sv =====
`timescale 1ns / 1ps

// Byte-serial CSV tokenizer. Raw text enters on the s_axis group, one byte
// per beat in s_tdata, with s_tlast set on the last byte of the text. Each
// byte that carries field content or ends a field gives one result beat on
// the m_axis group; quote characters, a skipped LF after CR and similar
// bytes give no beat. The cfg channel writes the delimiter (index 0) and
// the quote character (index 1); it is always ready, and the user must use
// it only while the block is idle, as the block does not enforce this.
// An accepted byte is held in the input register, and its result is
// registered in the output register when the state update advances.
// Throughput is one byte per cycle while the receiver does not stall.
// When the receiver stalls, the output register holds its beat, the input
// register fills, and s_tready falls only when both are occupied.
// Reset clears all parse state and the valid flags of both registers, and
// restores the comma delimiter and the double-quote character.

`include "csv_field_tokenizer_assert.svh"

module csv_field_tokenizer (
	input  logic clk,
	input  logic arst_n,
	input  logic s_tvalid,
	output logic s_tready,
	input  logic [csvt_pkg::BYTE_W-1:0] s_tdata,       // [7:0] data_byte
	input  logic s_tlast,                              // end_of_file
	output logic m_tvalid,
	input  logic m_tready,
	output logic [csvt_pkg::OUT_TDATA_W-1:0] m_tdata,  // [7:0] content_char,
	                                                   // [8] field_end,
	                                                   // [9] field_empty
	output logic m_tuser,                              // char_valid
	output logic m_tlast,                              // row_end
	input  logic cfg_valid,
	output logic cfg_ready,
	input  logic [csvt_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [csvt_pkg::BYTE_W-1:0] cfg_data
);
	import csvt_pkg::*;

	logic [BYTE_W-1:0] delimiter_q;
	logic [BYTE_W-1:0] quote_q;
	logic valid_s1;
	logic [BYTE_W-1:0] data_s1;
	logic last_s1;
	logic out_valid_q;
	csvt_result_t out_q;
	csvt_result_t result;
	csvt_state_t state;
	logic out_free;
	logic advance;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			delimiter_q <= RESET_DELIM;
			quote_q <= RESET_QUOTE;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_DELIMITER: delimiter_q <= cfg_data;
				REG_QUOTE: quote_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign out_free = !out_valid_q || m_tready;
	assign advance = valid_s1 && (!result.present || out_free);
	assign s_tready = !valid_s1 || advance;

	csvt_step u_step (
		.clk(clk),
		.arst_n(arst_n),
		.advance(advance),
		.data_byte(data_s1),
		.end_of_file(last_s1),
		.delimiter_char(delimiter_q),
		.quote_char(quote_q),
		.result(result),
		.state(state)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (s_tready) begin
				valid_s1 <= s_tvalid;
			end
			if (advance && result.present) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			data_s1 <= s_tdata;
			last_s1 <= s_tlast;
		end
		if (advance && result.present) begin
			out_q <= result;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata = {{(OUT_TDATA_W - BYTE_W - 2){1'b0}}, out_q.field_empty,
		out_q.field_end, out_q.content_char};
	assign m_tuser = out_q.char_valid;
	assign m_tlast = out_q.row_end;

	`CSVT_ASSERT_NOW(a_row_end_has_field_end, m_tvalid && m_tlast, m_tdata[8],
		"row end without field end")
	`CSVT_ASSERT_NOW(a_empty_without_char, m_tvalid && m_tdata[9], !m_tuser && m_tdata[8],
		"empty field flag with content byte or without field end")
	`CSVT_ASSERT_NEXT(a_eof_clears_state, advance && last_s1, state == '0,
		"parse state not cleared after end of file")
	`CSVT_ASSERT_NEXT(a_stall_holds_s1, valid_s1 && !advance,
		valid_s1 && $stable(data_s1) && $stable(last_s1),
		"input register changed while stalled")

endmodule
